[hw/rtl/czsc_pkg.sv]
// shared types and constants for the calorimeter zero suppression block
`timescale 1ns / 1ps

package czsc_pkg;

  localparam int unsigned ChannelW = 13;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned EnergyW  = 20;
  localparam int unsigned CountW   = 14;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 96;

  // output queue depth, room for two results per item in flight
  localparam int unsigned OqDepth  = 8;
  localparam int unsigned OqPtrW   = $clog2(OqDepth);
  localparam int unsigned OqCntW   = OqPtrW + 1;

  localparam logic [CountW-1:0]  COUNT_MAX   = '1;
  localparam logic [CfgIdxW-1:0] REG_ENABLE  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_HOT_THR = 1'd1;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;
  localparam logic KIND_HIT      = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // one calibration table row
  typedef struct packed {
    logic [ScaleW-1:0] energy_scale;
    logic [ScaleW-1:0] et_scale;
    logic [AdcW-1:0]   pedestal;
    logic [AdcW-1:0]   threshold;
  } calib_t;

  typedef struct packed {
    logic                kind;
    logic [ChannelW-1:0] hit_channel;
    logic [AdcW-1:0]     adc_above_ped;
    logic [EnergyW-1:0]  et_value;
    logic [EnergyW-1:0]  energy_value;
    logic [CountW-1:0]   tower_count;
    logic [CountW-1:0]   hot_count;
    logic                last;
  } result_t;

  // results written into the queue this cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

[hw/rtl/czsc_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps

module czsc_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/czsc_result_fifo.sv]
// result queue taking up to two results per cycle, one out per cycle while pop_i is high
`timescale 1ns / 1ps

module czsc_result_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  czsc_pkg::push_t                     push_i,
  input  czsc_pkg::result_t                   first_i,
  input  czsc_pkg::result_t                   second_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output czsc_pkg::result_t                   head_o,
  output logic [czsc_pkg::OqCntW-1:0]         count_o
);

  czsc_pkg::result_t                 mem_q [czsc_pkg::OqDepth];
  logic [czsc_pkg::OqPtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [czsc_pkg::OqCntW-1:0]       count_q, count_d;
  logic [czsc_pkg::OqPtrW-1:0]       wptr_next;
  logic [1:0]                        push_n;
  logic                              do_pop;

  assign push_n    = {1'b0, push_i.first} + {1'b0, push_i.second};
  assign do_pop    = pop_i && (count_q != '0);
  assign wptr_next = wptr_q + czsc_pkg::OqPtrW'(1);

  always_comb begin
    wptr_d  = wptr_q + czsc_pkg::OqPtrW'(push_n);
    rptr_d  = do_pop ? rptr_q + czsc_pkg::OqPtrW'(1) : rptr_q;
    count_d = count_q + czsc_pkg::OqCntW'(push_n) - czsc_pkg::OqCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wptr_q] <= first_i;
    end
    if (push_i.second) begin
      mem_q[wptr_next] <= second_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign count_o = count_q;

endmodule

[hw/rtl/calorimeter_zero_suppress_calibrate_top.sv]
// calorimeter zero suppression and gain calibration, top level
// path: the table ram read and the item stage are registered, then compare, subtract and
//   two multiplies feed the result queue, which offers the result
// throughput: one input item per cycle while the result queue has room; output moves
//   one result per cycle while m_axis_tready is high; a hit and its summary go out in turn
// reset: event counts clear, enable = 1, hot threshold = 256; tables hold nothing until loaded
`timescale 1ns / 1ps

module calorimeter_zero_suppress_calibrate_top #(
  parameter int unsigned CHANNELS = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: channel, raw_adc, threshold, pedestal, et_scale, energy_scale, data_valid
  input  logic [czsc_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tuser,   // action
  input  logic                            s_axis_tlast,   // event_end
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: hit_channel, adc_above_ped, et_value, energy_value, tower_count, hot_count
  output logic [czsc_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,   // kind
  output logic                            m_axis_tlast,   // last
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [czsc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [czsc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW = $clog2(CHANNELS);

  // input fields
  logic [czsc_pkg::ChannelW-1:0] in_channel;
  logic [czsc_pkg::AdcW-1:0]     in_raw;
  czsc_pkg::calib_t              in_calib;
  logic                          in_dv;
  logic                          in_accept;
  logic                          in_range;

  assign in_channel            = s_axis_tdata[12:0];
  assign in_raw                = s_axis_tdata[24:13];
  assign in_calib.threshold    = s_axis_tdata[36:25];
  assign in_calib.pedestal     = s_axis_tdata[48:37];
  assign in_calib.et_scale     = s_axis_tdata[64:49];
  assign in_calib.energy_scale = s_axis_tdata[80:65];
  assign in_dv                 = s_axis_tdata[81];

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_range  = (32'(in_channel) < CHANNELS);

  // configuration
  logic                         enable_q;
  logic [czsc_pkg::EnergyW-1:0] hot_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      hot_thr_q <= czsc_pkg::EnergyW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        czsc_pkg::REG_ENABLE:  enable_q  <= cfg_data_i[0];
        czsc_pkg::REG_HOT_THR: hot_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // calibration tables, one row per channel
  logic             ram_en;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  czsc_pkg::calib_t cal;

  assign ram_en   = in_accept && in_range;
  assign ram_we   = (s_axis_tuser == czsc_pkg::ACTION_LOAD);
  assign ram_addr = AddrW'(in_channel);

  czsc_ram #(
    .WIDTH ($bits(czsc_pkg::calib_t)),
    .DEPTH (CHANNELS)
  ) u_cal_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_calib),
    .rdata_o (cal)
  );

  // item stage, lines up with the ram read data
  logic                          s1_valid_q;
  logic                          s1_action_q;
  logic [czsc_pkg::ChannelW-1:0] s1_channel_q;
  logic [czsc_pkg::AdcW-1:0]     s1_raw_q;
  logic                          s1_dv_q;
  logic                          s1_end_q;
  logic                          s1_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q  <= s_axis_tuser;
      s1_channel_q <= in_channel;
      s1_raw_q     <= in_raw;
      s1_dv_q      <= in_dv;
      s1_end_q     <= s_axis_tlast;
      s1_range_q   <= in_range;
    end
  end

  // zero suppression and calibration
  logic                         hit;
  logic [czsc_pkg::AdcW-1:0]    adc;
  logic [27:0]                  et_prod, en_prod;
  logic [czsc_pkg::EnergyW-1:0] et_val, en_val;
  logic                         hot;

  assign hit = s1_valid_q && (s1_action_q == czsc_pkg::ACTION_SAMPLE) && s1_range_q
               && enable_q && s1_dv_q && (s1_raw_q >= cal.threshold);
  assign adc     = (s1_raw_q > cal.pedestal) ? s1_raw_q - cal.pedestal : '0;
  assign et_prod = 28'(adc) * 28'(cal.et_scale);
  assign en_prod = 28'(adc) * 28'(cal.energy_scale);
  assign et_val  = et_prod[27:8];
  assign en_val  = en_prod[27:8];
  assign hot     = (et_val > hot_thr_q);

  // event counters, saturating
  logic [czsc_pkg::CountW-1:0] towers_q, towers_d, hot_cnt_q, hot_cnt_d;
  logic [czsc_pkg::CountW-1:0] towers_now, hot_now;
  logic                        summary;

  assign summary = s1_valid_q && s1_end_q;

  always_comb begin
    towers_now = towers_q;
    hot_now    = hot_cnt_q;
    if (hit && (towers_q != czsc_pkg::COUNT_MAX)) begin
      towers_now = towers_q + czsc_pkg::CountW'(1);
    end
    if (hit && hot && (hot_cnt_q != czsc_pkg::COUNT_MAX)) begin
      hot_now = hot_cnt_q + czsc_pkg::CountW'(1);
    end
    towers_d  = summary ? '0 : towers_now;
    hot_cnt_d = summary ? '0 : hot_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      towers_q  <= '0;
      hot_cnt_q <= '0;
    end else begin
      towers_q  <= towers_d;
      hot_cnt_q <= hot_cnt_d;
    end
  end

  // result records
  czsc_pkg::result_t hit_res, sum_res, first_res;
  czsc_pkg::push_t   push;

  always_comb begin
    hit_res               = '0;
    hit_res.kind          = czsc_pkg::KIND_HIT;
    hit_res.hit_channel   = s1_channel_q;
    hit_res.adc_above_ped = adc;
    hit_res.et_value      = et_val;
    hit_res.energy_value  = en_val;
    hit_res.last          = !s1_end_q;

    sum_res             = '0;
    sum_res.kind        = czsc_pkg::KIND_SUMMARY;
    sum_res.tower_count = towers_now;
    sum_res.hot_count   = hot_now;
    sum_res.last        = 1'b1;

    first_res   = hit ? hit_res : sum_res;
    push.first  = hit || summary;
    push.second = hit && summary;
  end

  logic [czsc_pkg::OqCntW-1:0] oq_count;
  czsc_pkg::result_t           head;

  czsc_result_fifo u_result_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first_res),
    .second_i (sum_res),
    .pop_i    (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .head_o   (head),
    .count_o  (oq_count)
  );

  // take an item only while the queue has room for two results each for it and the one
  // still in the item stage
  logic [czsc_pkg::OqCntW:0] committed;

  assign committed     = {1'b0, oq_count} + (s1_valid_q ? (czsc_pkg::OqCntW+1)'(2) : '0);
  assign s_axis_tready = (committed <= (czsc_pkg::OqCntW+1)'(czsc_pkg::OqDepth - 2));

  assign m_axis_tdata = {3'b000, head.hot_count, head.tower_count, head.energy_value,
                         head.et_value, head.adc_above_ped, head.hit_channel};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

[tb/sv/tb.sv]
// testbench for the calorimeter zero suppression and gain calibration block
`timescale 1ns / 1ps

module tb;
  import czsc_pkg::*;

  localparam int unsigned TableDepth       = 8192;
  localparam int unsigned SettleCycles     = 8;
  localparam int unsigned CycleLimit       = 500000;
  localparam int unsigned LongEventSamples = 200;

  typedef struct {
    logic                action;
    logic [ChannelW-1:0] channel;
    logic [AdcW-1:0]     raw_adc;
    logic [AdcW-1:0]     threshold;
    logic [AdcW-1:0]     pedestal;
    logic [ScaleW-1:0]   et_scale;
    logic [ScaleW-1:0]   energy_scale;
    logic                data_valid;
    logic                event_end;
  } readout_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  // calibration and event state as the block should hold it
  logic [AdcW-1:0]     thr_tab    [TableDepth];
  logic [AdcW-1:0]     ped_tab    [TableDepth];
  logic [ScaleW-1:0]   et_tab     [TableDepth];
  logic [ScaleW-1:0]   energy_tab [TableDepth];
  bit                  loaded     [TableDepth];
  int unsigned         loaded_q   [$];
  logic [CountW-1:0]   towers_now;
  logic [CountW-1:0]   hot_now;
  logic                cfg_enable;
  logic [CfgDataW-1:0] cfg_hot_thr;

  result_t     pending_results [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned hits_seen;
  int unsigned summaries_seen;
  int unsigned cycle_count;
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned hold_off_left;

  calorimeter_zero_suppress_calibrate_top #(
    .CHANNELS(TableDepth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[calorimeter_zero_suppress_calibrate_top] ERROR");
      $finish;
    end
  end

  // expected results of one accepted item, state updated as the block does
  function automatic void calibrate_and_count(input readout_t it);
    result_t     r;
    int unsigned adc;
    int unsigned et;
    int unsigned en;
    if (it.action == ACTION_LOAD) begin
      if (it.channel < TableDepth) begin
        thr_tab[it.channel]    = it.threshold;
        ped_tab[it.channel]    = it.pedestal;
        et_tab[it.channel]     = it.et_scale;
        energy_tab[it.channel] = it.energy_scale;
        if (!loaded[it.channel]) loaded_q.push_back(32'(it.channel));
        loaded[it.channel] = 1'b1;
      end
    end else if (it.channel < TableDepth && cfg_enable && it.data_valid &&
                 it.raw_adc >= thr_tab[it.channel]) begin
      adc = (it.raw_adc > ped_tab[it.channel]) ?
            32'(it.raw_adc) - 32'(ped_tab[it.channel]) : 0;
      et  = (adc * 32'(et_tab[it.channel])) >> 8;
      en  = (adc * 32'(energy_tab[it.channel])) >> 8;
      r = '0;
      r.kind          = KIND_HIT;
      r.hit_channel   = it.channel;
      r.adc_above_ped = adc[AdcW-1:0];
      r.et_value      = et[EnergyW-1:0];
      r.energy_value  = en[EnergyW-1:0];
      r.last          = !it.event_end;
      pending_results.push_back(r);
      if (towers_now < COUNT_MAX) towers_now++;
      if (et > cfg_hot_thr && hot_now < COUNT_MAX) hot_now++;
    end
    if (it.event_end) begin
      r = '0;
      r.kind        = KIND_SUMMARY;
      r.tower_count = towers_now;
      r.hot_count   = hot_now;
      r.last        = 1'b1;
      pending_results.push_back(r);
      towers_now = '0;
      hot_now    = '0;
    end
  endfunction

  function automatic readout_t make_load(input int unsigned ch, input int unsigned thr,
                                         input int unsigned ped, input int unsigned ets,
                                         input int unsigned ens, input bit ev_end);
    readout_t it;
    it = '{default: '0};
    it.action       = ACTION_LOAD;
    it.channel      = ChannelW'(ch);
    it.threshold    = AdcW'(thr);
    it.pedestal     = AdcW'(ped);
    it.et_scale     = ScaleW'(ets);
    it.energy_scale = ScaleW'(ens);
    it.event_end    = ev_end;
    return it;
  endfunction

  function automatic readout_t make_sample(input int unsigned ch, input int unsigned raw,
                                           input bit dv, input bit ev_end);
    readout_t it;
    it = '{default: '0};
    it.action     = ACTION_SAMPLE;
    it.channel    = ChannelW'(ch);
    it.raw_adc    = AdcW'(raw);
    it.data_valid = dv;
    it.event_end  = ev_end;
    return it;
  endfunction

  // mostly samples near the channel threshold on loaded channels, some reloads
  function automatic readout_t random_readout();
    readout_t    it;
    int unsigned ch;
    int unsigned thr;
    int          raw_try;
    if ($urandom_range(0, 99) < 10 || loaded_q.size() == 0) begin
      thr = $urandom_range(0, 4095);
      it = make_load($urandom_range(0, 8191), thr,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, thr),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0);
      // random words on the unused sample fields
      it.raw_adc    = AdcW'($urandom_range(0, 4095));
      it.data_valid = 1'($urandom_range(0, 1));
    end else begin
      ch = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
      if ($urandom_range(0, 2) == 0) begin
        raw_try = $urandom_range(0, 4095);
      end else begin
        raw_try = int'(thr_tab[ch]) + int'($urandom_range(0, 400)) - 40;
        if (raw_try < 0) raw_try = 0;
        if (raw_try > 4095) raw_try = 4095;
      end
      it = make_sample(ch, unsigned'(raw_try), $urandom_range(0, 9) != 0, 1'b0);
      it.threshold    = AdcW'($urandom_range(0, 4095));
      it.pedestal     = AdcW'($urandom_range(0, 4095));
      it.et_scale     = ScaleW'($urandom_range(0, 65535));
      it.energy_scale = ScaleW'($urandom_range(0, 65535));
    end
    it.event_end = ($urandom_range(0, 11) == 0);
    return it;
  endfunction

  task automatic send_item(input readout_t it);
    int unsigned gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {6'b0, it.data_valid, it.energy_scale, it.et_scale, it.pedestal,
                     it.threshold, it.raw_adc, it.channel};
    s_axis_tuser  = it.action;
    s_axis_tlast  = it.event_end;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    calibrate_and_count(it);
    items_sent++;
  endtask

  // stop offering, let every expected result arrive and the pipe empty
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ENABLE) cfg_enable = value[0];
    else cfg_hot_thr = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_item(random_readout());
  endtask

  task automatic test_directed();
    send_item(make_load(0, 0, 0, 65535, 65535, 1'b0));
    send_item(make_load(8191, 100, 4095, 65535, 1, 1'b0));
    send_item(make_load(12'hAAA, 2048, 10, 16'h8000, 16'h1234, 1'b0));
    send_item(make_load(13'h1555, 4095, 0, 65535, 0, 1'b0));
    send_item(make_sample(0, 4095, 1'b1, 1'b0));        // largest product
    send_item(make_sample(0, 0, 1'b1, 1'b0));           // zero raw at zero threshold
    send_item(make_sample(12'hAAA, 2048, 1'b1, 1'b0));  // exactly at threshold
    send_item(make_sample(12'hAAA, 2047, 1'b1, 1'b0));  // one below threshold
    send_item(make_sample(8191, 200, 1'b1, 1'b0));      // pedestal above value
    send_item(make_sample(13'h1555, 4095, 1'b1, 1'b0));
    send_item(make_sample(13'h1555, 4094, 1'b1, 1'b0));
    send_item(make_sample(0, 500, 1'b0, 1'b0));         // no barrel data
    send_item(make_sample(0, 300, 1'b1, 1'b1));         // hit then summary
    send_item(make_load(100, 4095, 4095, 65535, 65535, 1'b1));  // summary on a load
    send_item(make_sample(12'hAAA, 5, 1'b1, 1'b1));     // summary without a hit
    send_item(make_sample(100, 4095, 1'b1, 1'b0));
    send_item(make_sample(13'h1555, 4095, 1'b1, 1'b1));
    // channel beyond the table cannot be formed: the channel field spans the full depth
  endtask

  task automatic test_config_sweep();
    logic [CfgDataW-1:0] hot_sel [5];
    logic                en_sel  [5];
    en_sel  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    hot_sel = '{20'd256, 20'd0, '1, 20'd0, 20'd256};
    hot_sel[3] = CfgDataW'($urandom_range(1, 1 << 17));
    for (int i = 0; i < 5; i++) begin
      wait_idle();
      write_reg(REG_ENABLE, {19'b0, en_sel[i]});
      write_reg(REG_HOT_THR, hot_sel[i]);
      send_random(60);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_off_left = 300;
    send_random(80);
    wait_idle();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // one long event where every hit is hot
  task automatic test_long_event();
    wait_idle();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_reg(REG_HOT_THR, '0);
    send_item(make_load(7, 0, 0, 65535, 65535, 1'b0));
    repeat (LongEventSamples - 1) send_item(make_sample(7, 4095, 1'b1, 1'b0));
    send_item(make_sample(7, 4095, 1'b1, 1'b1));
    wait_idle();
    write_reg(REG_HOT_THR, CfgDataW'($urandom_range(1, 1 << 17)));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random();
    send_random(400);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random(200);
  endtask

  // receiver side: random stall bursts plus a long hold-off when asked
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        m_axis_tready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d tdata %h",
               m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.kind == KIND_HIT) hits_seen++;
        else summaries_seen++;
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("hit_channel", 32'(want.hit_channel), 32'(m_axis_tdata[12:0]));
        check_field("adc_above_ped", 32'(want.adc_above_ped), 32'(m_axis_tdata[24:13]));
        check_field("et_value", 32'(want.et_value), 32'(m_axis_tdata[44:25]));
        check_field("energy_value", 32'(want.energy_value), 32'(m_axis_tdata[64:45]));
        check_field("tower_count", 32'(want.tower_count), 32'(m_axis_tdata[78:65]));
        check_field("hot_count", 32'(want.hot_count), 32'(m_axis_tdata[92:79]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ENABLE;
    cfg_data_i    = '0;
    towers_now    = '0;
    hot_now       = '0;
    cfg_enable    = 1'b1;
    cfg_hot_thr   = 20'd256;
    errors        = 0;
    items_sent    = 0;
    hits_seen     = 0;
    summaries_seen = 0;
    cycle_count   = 0;
    hold_off_left = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_long_event();
    test_random();
    wait_idle();

    $display("run: %0d items in, %0d hits and %0d event summaries checked",
             items_sent, hits_seen, summaries_seen);
    $display("covered enable off/on, hot threshold 0 to full scale, a long all-hot event, "
             , "long output hold-off");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[calorimeter_zero_suppress_calibrate_top] OK");
    end else begin
      $display("[calorimeter_zero_suppress_calibrate_top] ERROR");
    end
    $finish;
  end

endmodule
